>>> src/psd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psd_pkg: shared types and constants
// Widths and the stage payload used by the pipelined point-to-segment block.
// ---------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned DiffW  = 25;
  localparam int unsigned Ab2W   = 50;
  localparam int unsigned DotW   = 51;
  localparam int unsigned TFracW = 16;
  localparam int unsigned TW     = 17;
  localparam int unsigned DistW  = 52;
  localparam int unsigned RemW   = 51;

  // payload handed from one divider cell to the next
  typedef struct packed {
    logic signed [DiffW-1:0] apx;
    logic signed [DiffW-1:0] apy;
    logic signed [DiffW-1:0] abx;
    logic signed [DiffW-1:0] aby;
    logic [Ab2W-1:0]         ab2;
    logic [RemW-1:0]         rem;
    logic [TW-1:0]           quo;
    logic                    clamp;
    logic                    degen;
  } div_t;

endpackage

>>> src/psd_div_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psd_div_cell: one restoring division step
// Produces one quotient bit of t (unless the item is clamped) and passes the item to the next cell.
// ---------------------------------------------------------------------------
module psd_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  psd_pkg::div_t    data_i,
  output logic             valid_o,
  output psd_pkg::div_t    data_o
);

  logic                      valid_q;
  psd_pkg::div_t             data_q, data_d;
  logic [psd_pkg::RemW:0]    shifted;

  // shift remainder and try a subtract
  always_comb begin
    data_d  = data_i;
    shifted = {data_i.rem, 1'b0};
    if (!data_i.clamp && (shifted >= {2'b00, data_i.ab2})) begin
      data_d.rem = psd_pkg::RemW'(shifted - {2'b00, data_i.ab2});
      data_d.quo = {data_i.quo[psd_pkg::TW-2:0], 1'b1};
    end else begin
      data_d.rem = psd_pkg::RemW'(shifted);
      data_d.quo = data_i.clamp ? data_i.quo : {data_i.quo[psd_pkg::TW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> src/point_segment_distance_sq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_segment_distance_sq: squared distance from a point to a segment
// Projects P onto segment AB, clamps t to [0,1], returns squared distance.
// ---------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while the pipe is
// not stalled. It passes 3 setup stages, a chain of 16 divider cells that each
// form one bit of t, and 4 stages for the products and the final sum. The
// whole pipe advances together and stalls only while the output is held.
module point_segment_distance_sq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [23:0]  point_x_i,
  input  logic signed [23:0]  point_y_i,
  input  logic signed [23:0]  start_x_i,
  input  logic signed [23:0]  start_y_i,
  input  logic signed [23:0]  end_x_i,
  input  logic signed [23:0]  end_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [51:0]         dist_sq_o,
  output logic [16:0]         proj_t_o,
  output logic                degenerate_o
);

  localparam int unsigned NCells = psd_pkg::TFracW;
  localparam int unsigned DW = psd_pkg::DiffW;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: differences
  logic s1_v_q;
  logic signed [DW-1:0] s1_apx_q, s1_apy_q, s1_abx_q, s1_aby_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_apx_q <= DW'(point_x_i) - DW'(start_x_i);
      s1_apy_q <= DW'(point_y_i) - DW'(start_y_i);
      s1_abx_q <= DW'(end_x_i) - DW'(start_x_i);
      s1_aby_q <= DW'(end_y_i) - DW'(start_y_i);
    end
  end

  // stage 2: four products
  logic s2_v_q;
  logic signed [DW-1:0] s2_apx_q, s2_apy_q, s2_abx_q, s2_aby_q;
  logic signed [2*DW-1:0] s2_xx_q, s2_yy_q, s2_dx_q, s2_dy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_apx_q <= s1_apx_q; s2_apy_q <= s1_apy_q;
      s2_abx_q <= s1_abx_q; s2_aby_q <= s1_aby_q;
      s2_xx_q <= s1_abx_q * s1_abx_q;
      s2_yy_q <= s1_aby_q * s1_aby_q;
      s2_dx_q <= s1_apx_q * s1_abx_q;
      s2_dy_q <= s1_apy_q * s1_aby_q;
    end
  end

  // stage 3: sums, clamp decision, seed the divider chain
  logic [psd_pkg::Ab2W-1:0]         ab2;
  logic signed [psd_pkg::DotW-1:0]  dot;
  psd_pkg::div_t                    seed_d;
  logic                             s3_v_q;
  psd_pkg::div_t                    s3_q;
  always_comb begin
    ab2 = psd_pkg::Ab2W'(s2_xx_q) + psd_pkg::Ab2W'(s2_yy_q);
    dot = psd_pkg::DotW'(s2_dx_q) + psd_pkg::DotW'(s2_dy_q);
    seed_d.apx = s2_apx_q; seed_d.apy = s2_apy_q;
    seed_d.abx = s2_abx_q; seed_d.aby = s2_aby_q;
    seed_d.ab2 = ab2;
    seed_d.rem = psd_pkg::RemW'(dot);
    seed_d.degen = (ab2 == '0);
    if (ab2 == '0 || dot <= 0) begin
      seed_d.clamp = 1'b1;
      seed_d.quo   = '0;
    end else if ($signed({1'b0, ab2}) <= dot) begin
      seed_d.clamp = 1'b1;
      seed_d.quo   = psd_pkg::TW'(1) << psd_pkg::TFracW;
    end else begin
      seed_d.clamp = 1'b0;
      seed_d.quo   = '0;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) s3_q <= seed_d;
  end

  // chain of divider cells
  logic          cv [NCells+1];
  psd_pkg::div_t cd [NCells+1];
  assign cv[0] = s3_v_q;
  assign cd[0] = s3_q;
  for (genvar g = 0; g < NCells; g++) begin : g_cell
    psd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[g]),
      .data_i  (cd[g]),
      .valid_o (cv[g+1]),
      .data_o  (cd[g+1])
    );
  end

  // stage 4: ab * t
  psd_pkg::div_t c_o;
  assign c_o = cd[NCells];
  logic s4_v_q;
  logic signed [DW-1:0] s4_apx_q, s4_apy_q;
  logic signed [DW+psd_pkg::TW:0] s4_px_q, s4_py_q;
  logic [psd_pkg::TW-1:0] s4_t_q;
  logic s4_dg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= cv[NCells];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_apx_q <= c_o.apx; s4_apy_q <= c_o.apy;
      s4_t_q   <= c_o.quo; s4_dg_q <= c_o.degen;
      s4_px_q  <= c_o.abx * $signed({1'b0, c_o.quo});
      s4_py_q  <= c_o.aby * $signed({1'b0, c_o.quo});
    end
  end

  // stage 5: offsets with floor shift
  logic s5_v_q;
  logic signed [DW:0] s5_dx_q, s5_dy_q;
  logic [psd_pkg::TW-1:0] s5_t_q;
  logic s5_dg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en) s5_v_q <= s4_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_dx_q <= (DW+1)'(s4_apx_q) - (DW+1)'(s4_px_q >>> psd_pkg::TFracW);
      s5_dy_q <= (DW+1)'(s4_apy_q) - (DW+1)'(s4_py_q >>> psd_pkg::TFracW);
      s5_t_q  <= s4_t_q; s5_dg_q <= s4_dg_q;
    end
  end

  // stage 6: squares
  logic s6_v_q;
  logic signed [2*DW+1:0] s6_xx_q, s6_yy_q;
  logic [psd_pkg::TW-1:0] s6_t_q;
  logic s6_dg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_v_q <= 1'b0;
    else if (en) s6_v_q <= s5_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_xx_q <= s5_dx_q * s5_dx_q;
      s6_yy_q <= s5_dy_q * s5_dy_q;
      s6_t_q  <= s5_t_q; s6_dg_q <= s5_dg_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= s6_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_sq_o    <= psd_pkg::DistW'(s6_xx_q) + psd_pkg::DistW'(s6_yy_q);
      proj_t_o     <= s6_t_q;
      degenerate_o <= s6_dg_q;
    end
  end

endmodule
